[hdl/mcmv_pkg.sv]
// Shared types, sizes and helpers of the complex matrix-vector multiply block.
package mcmv_pkg;

  localparam int NumSubcarriers = 2048;
  localparam int NumRx          = 8;
  localparam int NumTx          = 8;

  localparam int ScW   = 11;
  localparam int RxW   = 3;
  localparam int TxW   = 3;
  localparam int CompW = 16;
  localparam int ProdW = 2 * CompW;
  localparam int AccW  = 36;

  // Each cell stores one matrix row for every subcarrier and receive antenna.
  localparam int CellDepth = NumSubcarriers * NumRx;
  localparam int CoefAw    = $clog2(CellDepth);

  typedef enum logic [0:0] {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef logic [TxW-1:0]    tx_idx_t;
  typedef logic [CoefAw-1:0] coef_addr_t;

  typedef struct packed {
    logic signed [CompW-1:0] im;
    logic signed [CompW-1:0] re;
  } cplx16_t;

  typedef struct packed {
    op_e                     opcode;
    logic [ScW-1:0]          subcarrier;
    logic [RxW-1:0]          rx_index;
    logic [TxW-1:0]          tx_index;
    logic signed [CompW-1:0] sample_real;
    logic signed [CompW-1:0] sample_imag;
  } in_t;

  typedef struct packed {
    logic [ScW-1:0]         out_subcarrier;
    logic [TxW-1:0]         out_tx;
    logic signed [AccW-1:0] out_real;
    logic signed [AccW-1:0] out_imag;
    logic                   last;
  } out_t;

  // One stage of the result drain chain.
  typedef struct packed {
    logic valid;
    out_t data;
  } slot_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic           adv;
    logic           wr_en;
    tx_idx_t        wr_tx;
    coef_addr_t     addr;
    cplx16_t        wr_data;
    cplx16_t        x;
    logic           acc_en;
    logic           acc_close;
    logic           drain_load;
    logic           drain_shift;
    logic [ScW-1:0] sc;
  } cell_ctrl_t;

  function automatic coef_addr_t coef_addr(logic [ScW-1:0] sc, logic [RxW-1:0] rx);
    return CoefAw'(int'(sc) * NumRx + int'(rx));
  endfunction

endpackage

[hdl/mimo_complex_matrix_vector_multiply.sv]
// Top level of the per-subcarrier MIMO complex matrix-vector multiply.
//
// A request either loads one complex coefficient H[tx][rx] of a subcarrier
// (opcode OP_LOAD) or delivers one received sample x[rx] (OP_SAMPLE). Every
// sample is multiplied by column rx of its subcarrier's matrix and added into
// NumTx complex accumulators; the sample with rx_index == NumRx-1 closes the
// run and produces NumTx results, stream 0 first, each a full-precision 36-bit
// complex sum, with last set on the final stream. The block takes one request
// per clock while in_ready_o is high. A sample passes the coefficient read and
// product registers into the accumulators; a closing sum enters the drain chain
// at that same edge. The datapath is a row of NumTx identical cells, one per
// transmit stream; each cell owns its row of every matrix in a single-port
// memory, a registered complex multiplier and its accumulator. Results leave
// through a shift chain along the same cells, one result per cycle from
// cell 0 while the consumer takes them. Because a run emits NumTx results,
// a closing sample stalls the pipeline (in_ready_o low) when the chain still
// holds results of the previous run beyond the one leaving now; with runs of
// NumRx >= NumTx samples and a consumer that always takes results, requests
// flow at one per cycle. Out-of-range indices are dropped. Coefficients read
// before being written give undefined results; there is no clearing pass.
module mimo_complex_matrix_vector_multiply (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mcmv_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mcmv_pkg::out_t  out_data_o
);

  mcmv_pkg::cell_ctrl_t ctrl;
  mcmv_pkg::slot_t      chain [mcmv_pkg::NumTx+1];

  logic                     accept;
  logic                     idx_ok;
  logic                     tx_ok;
  logic                     load_ok;
  logic                     adv;

  // Stage 1: coefficient read in flight.
  logic                     s1_valid_q;
  logic                     s1_close_q;
  logic [mcmv_pkg::ScW-1:0] s1_sc_q;
  mcmv_pkg::cplx16_t        s1_x_q;

  // Stage 2: products ready for accumulation.
  logic                     s2_valid_q;
  logic                     s2_close_q;
  logic [mcmv_pkg::ScW-1:0] s2_sc_q;

  assign idx_ok = (int'(in_data_i.subcarrier) < mcmv_pkg::NumSubcarriers) &&
                  (int'(in_data_i.rx_index) < mcmv_pkg::NumRx);
  assign tx_ok  = int'(in_data_i.tx_index) < mcmv_pkg::NumTx;

  // The drain chain can take a new run if it is empty or its last result
  // leaves in this cycle.
  assign load_ok = !chain[0].valid || (!chain[1].valid && out_ready_i);

  // Hold the whole pipeline while a closing sample waits for the chain.
  assign adv        = !(s2_valid_q && s2_close_q && !load_ok);
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept && idx_ok && (in_data_i.opcode == mcmv_pkg::OP_SAMPLE);
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_close_q <= int'(in_data_i.rx_index) == mcmv_pkg::NumRx - 1;
      s1_sc_q    <= in_data_i.subcarrier;
      s1_x_q.re  <= in_data_i.sample_real;
      s1_x_q.im  <= in_data_i.sample_imag;
      s2_close_q <= s1_close_q;
      s2_sc_q    <= s1_sc_q;
    end
  end

  always_comb begin
    ctrl             = '0;
    ctrl.adv         = adv;
    ctrl.wr_en       = accept && idx_ok && tx_ok && (in_data_i.opcode == mcmv_pkg::OP_LOAD);
    ctrl.wr_tx       = in_data_i.tx_index;
    ctrl.addr        = mcmv_pkg::coef_addr(in_data_i.subcarrier, in_data_i.rx_index);
    ctrl.wr_data.re  = in_data_i.sample_real;
    ctrl.wr_data.im  = in_data_i.sample_imag;
    ctrl.x           = s1_x_q;
    ctrl.acc_en      = s2_valid_q && adv;
    ctrl.acc_close   = s2_close_q;
    ctrl.drain_load  = s2_valid_q && adv && s2_close_q;
    ctrl.drain_shift = out_ready_i || !chain[0].valid;
    ctrl.sc          = s2_sc_q;
  end

  // Nothing enters the far end of the drain chain.
  assign chain[mcmv_pkg::NumTx] = '0;

  for (genvar j = 0; j < mcmv_pkg::NumTx; j++) begin : g_cell
    mcmv_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (mcmv_pkg::TxW'(j)),
      .ctrl_i (ctrl),
      .nxt_i  (chain[j+1]),
      .slot_o (chain[j])
    );
  end

  assign out_valid_o = chain[0].valid;
  assign out_data_o  = chain[0].data;

endmodule

[hdl/mcmv_cell.sv]
// One matrix row cell: coefficient memory, complex multiplier, accumulator, drain stage.
module mcmv_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mcmv_pkg::tx_idx_t       idx_i,
  input  mcmv_pkg::cell_ctrl_t    ctrl_i,
  input  mcmv_pkg::slot_t         nxt_i,
  output mcmv_pkg::slot_t         slot_o
);

  mcmv_pkg::cplx16_t mem [mcmv_pkg::CellDepth];
  mcmv_pkg::cplx16_t coef_q;

  logic signed [mcmv_pkg::ProdW-1:0] rr_q, ii_q, ir_q, ri_q;
  logic signed [mcmv_pkg::AccW-1:0]  acc_re_q, acc_im_q;
  logic signed [mcmv_pkg::AccW-1:0]  sum_re, sum_im;
  logic                              slot_v_q;
  mcmv_pkg::out_t                    slot_data_q;
  logic                              wr_en;

  assign wr_en = ctrl_i.wr_en && (ctrl_i.wr_tx == idx_i);

  // Registered-read coefficient store.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[ctrl_i.addr] <= ctrl_i.wr_data;
    end
    if (ctrl_i.adv) begin
      coef_q <= mem[ctrl_i.addr];
    end
  end

  // Four real products of H[j][k] * x[k].
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      rr_q <= $signed(coef_q.re) * $signed(ctrl_i.x.re);
      ii_q <= $signed(coef_q.im) * $signed(ctrl_i.x.im);
      ir_q <= $signed(coef_q.im) * $signed(ctrl_i.x.re);
      ri_q <= $signed(coef_q.re) * $signed(ctrl_i.x.im);
    end
  end

  assign sum_re = acc_re_q + {{(mcmv_pkg::AccW-mcmv_pkg::ProdW){rr_q[mcmv_pkg::ProdW-1]}}, rr_q}
                           - {{(mcmv_pkg::AccW-mcmv_pkg::ProdW){ii_q[mcmv_pkg::ProdW-1]}}, ii_q};
  assign sum_im = acc_im_q + {{(mcmv_pkg::AccW-mcmv_pkg::ProdW){ir_q[mcmv_pkg::ProdW-1]}}, ir_q}
                           + {{(mcmv_pkg::AccW-mcmv_pkg::ProdW){ri_q[mcmv_pkg::ProdW-1]}}, ri_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_re_q <= ctrl_i.acc_close ? '0 : sum_re;
      acc_im_q <= ctrl_i.acc_close ? '0 : sum_im;
    end
  end

  // Drain stage: load the closed sum, otherwise take the neighbor's result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_v_q <= 1'b0;
    end else if (ctrl_i.drain_load) begin
      slot_v_q <= 1'b1;
    end else if (ctrl_i.drain_shift) begin
      slot_v_q <= nxt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.drain_load) begin
      slot_data_q.out_subcarrier <= ctrl_i.sc;
      slot_data_q.out_tx         <= idx_i;
      slot_data_q.out_real       <= sum_re;
      slot_data_q.out_imag       <= sum_im;
      slot_data_q.last           <= (idx_i == mcmv_pkg::TxW'(mcmv_pkg::NumTx - 1));
    end else if (ctrl_i.drain_shift) begin
      slot_data_q <= nxt_i.data;
    end
  end

  assign slot_o.valid = slot_v_q;
  assign slot_o.data  = slot_data_q;

endmodule

[hdl/mcmv_checker.sv]
// Port-level checks of the complex matrix-vector multiply result stream.
module mcmv_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input mcmv_pkg::out_t  out_data_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Results of a run follow back to back with rising stream index.
  a_burst_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=>
      out_valid_o &&
      (out_data_o.out_tx == mcmv_pkg::TxW'($past(out_data_o.out_tx) + 1'b1)) &&
      (out_data_o.out_subcarrier == $past(out_data_o.out_subcarrier)))
    else $error("run results not contiguous");

  // A run starts at stream zero.
  a_burst_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> out_data_o.out_tx == '0)
    else $error("run does not start at stream zero");

  // Last marks exactly the final stream.
  a_last_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.last == (out_data_o.out_tx == mcmv_pkg::TxW'(mcmv_pkg::NumTx - 1))))
    else $error("last flag does not match final stream");

endmodule

bind mimo_complex_matrix_vector_multiply mcmv_checker u_mcmv_checker (.*);
